// ===== src/gpm_pkg.sv =====
// Package for the gamepad serial poll master: shared types, codes and packet tables.
// It depends on nothing. The engine, the response register and the top level use it.
package gpm_pkg;

   // Default number of bytes in a poll packet.
   localparam int POLL_BYTES = 21;

   // Widths of the fixed fields.
   localparam int HALF_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 5;
   localparam int LEN_W   = 6;

   // Configuration reset value: ticks per half clock period.
   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd400;

   // Request action codes.
   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_POLL = 2'd1;
   localparam logic [1:0] ACT_INIT = 2'd2;

   // Packet numbers within an init job.
   localparam logic [1:0] PKT_POLL  = 2'd0;
   localparam logic [1:0] PKT_ENTER = 2'd1;
   localparam logic [1:0] PKT_LOCK  = 2'd2;
   localparam logic [1:0] PKT_EXIT  = 2'd3;

   // Lengths of the configuration packets.
   localparam logic [LEN_W-1:0] ENTER_LEN = 6'd5;
   localparam logic [LEN_W-1:0] CFG_LEN   = 6'd9;

   // Command byte values.
   localparam logic [BYTE_W-1:0] BYTE_HEADER  = 8'h01;
   localparam logic [BYTE_W-1:0] BYTE_POLL    = 8'h42;
   localparam logic [BYTE_W-1:0] BYTE_CONFIG  = 8'h43;
   localparam logic [BYTE_W-1:0] BYTE_ANALOG  = 8'h44;
   localparam logic [BYTE_W-1:0] BYTE_LOCK    = 8'h03;
   localparam logic [BYTE_W-1:0] BYTE_PAD     = 8'h5A;
   localparam logic [BYTE_W-1:0] BYTE_ZERO    = 8'h00;

   // Job state of the engine.
   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_POLL = 3'b010,
      MODE_INIT = 3'b100
   } mode_type;

   // One response as it travels from the engine to the response register.
   typedef struct packed {
      logic               clock_pin;
      logic               command_pin;
      logic               attention_pin;
      logic               rx_valid;
      logic [BYTE_W-1:0]  rx_byte;
      logic [INDEX_W-1:0] rx_index;
      logic               packet_last;
      logic               sequence_done;
      logic               busy_res;
   } result_type;

   // Byte to send at a given position of a given packet.
   // The poll packet is a header, the poll command, then zeros to its end.
   function automatic logic [BYTE_W-1:0] pkt_byte(input logic [1:0] pkt,
                                                 input logic [INDEX_W-1:0] idx);
      logic [BYTE_W-1:0] value;
      value = BYTE_ZERO;
      unique case (pkt)
         PKT_POLL: begin
            if (idx == 5'd0) value = BYTE_HEADER;
            else if (idx == 5'd1) value = BYTE_POLL;
         end
         PKT_ENTER: begin
            if (idx == 5'd0) value = BYTE_HEADER;
            else if (idx == 5'd1) value = BYTE_CONFIG;
            else if (idx == 5'd3) value = BYTE_HEADER;
         end
         PKT_LOCK: begin
            if (idx == 5'd0) value = BYTE_HEADER;
            else if (idx == 5'd1) value = BYTE_ANALOG;
            else if (idx == 5'd3) value = BYTE_HEADER;
            else if (idx == 5'd4) value = BYTE_LOCK;
         end
         PKT_EXIT: begin
            if (idx == 5'd0) value = BYTE_HEADER;
            else if (idx == 5'd1) value = BYTE_CONFIG;
            else if (idx >= 5'd4 && idx <= 5'd8) value = BYTE_PAD;
         end
         default: value = BYTE_ZERO;
      endcase
      return value;
   endfunction

endpackage

// ===== src/gpm_engine.sv =====
// Serial timing engine: job state, bit and byte counters, shift registers and
// the half-period register. Depends on gpm_pkg for codes, tables and the result type.
module gpm_engine #(
   parameter int PollBytes = gpm_pkg::POLL_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [1:0]                        action,
   input  logic                              data_pin,
   input  logic                              csr_wr_en,
   input  logic [gpm_pkg::HALF_W-1:0]        csr_wr_data,
   output gpm_pkg::result_type               result
);

   localparam logic [gpm_pkg::LEN_W-1:0] POLL_LEN = gpm_pkg::LEN_W'(PollBytes);

   // State registers and their next values.
   gpm_pkg::mode_type                 mode_ff, mode_in;
   logic [1:0]                        pkt_ff, pkt_in;
   logic [gpm_pkg::INDEX_W-1:0]       byte_ff, byte_in;
   logic [2:0]                        bit_ff, bit_in;
   logic                              high_ff, high_in;
   logic                              gap_ff, gap_in;
   logic [gpm_pkg::HALF_W-1:0]        tick_ff, tick_in;
   logic [gpm_pkg::BYTE_W-1:0]        tx_ff, tx_in;
   logic [gpm_pkg::BYTE_W-1:0]        rx_ff, rx_in;
   logic [gpm_pkg::HALF_W-1:0]        half_ff;

   logic [gpm_pkg::HALF_W-1:0]        half_eff;
   logic [gpm_pkg::LEN_W-1:0]         pkt_len;
   logic [gpm_pkg::LEN_W-1:0]         byte_next_cnt;
   logic [gpm_pkg::INDEX_W-1:0]       byte_next;
   logic [gpm_pkg::BYTE_W-1:0]        rx_sampled;
   logic                              busy_next;
   logic                              in_pkt;
   logic                              rx_valid;
   logic [gpm_pkg::BYTE_W-1:0]        rx_byte;
   logic [gpm_pkg::INDEX_W-1:0]       rx_index;
   logic                              packet_last;
   logic                              done;

   // Length of the current packet; the poll packet length comes from the parameter.
   always_comb begin
      unique case (pkt_ff)
         gpm_pkg::PKT_POLL:  pkt_len = POLL_LEN;
         gpm_pkg::PKT_ENTER: pkt_len = gpm_pkg::ENTER_LEN;
         default:            pkt_len = gpm_pkg::CFG_LEN;
      endcase
   end

   // A zero half period counts as one tick.
   assign half_eff      = (half_ff == '0) ? gpm_pkg::HALF_W'(1) : half_ff;
   assign byte_next_cnt = {1'b0, byte_ff} + gpm_pkg::LEN_W'(1);
   assign byte_next     = byte_ff + gpm_pkg::INDEX_W'(1);
   assign rx_sampled    = rx_ff | (gpm_pkg::BYTE_W'(data_pin) << bit_ff);

   // Next state for one tick.
   always_comb begin
      mode_in     = mode_ff;
      pkt_in      = pkt_ff;
      byte_in     = byte_ff;
      bit_in      = bit_ff;
      high_in     = high_ff;
      gap_in      = gap_ff;
      tick_in     = tick_ff;
      tx_in       = tx_ff;
      rx_in       = rx_ff;
      rx_valid    = 1'b0;
      rx_byte     = '0;
      rx_index    = '0;
      packet_last = 1'b0;
      done        = 1'b0;

      unique case (mode_ff)
         gpm_pkg::MODE_POLL, gpm_pkg::MODE_INIT: begin
            if (tick_ff < half_eff) begin
               tick_in = tick_ff + gpm_pkg::HALF_W'(1);
            end else begin
               tick_in = gpm_pkg::HALF_W'(1);
               if (gap_ff) begin
                  // Gap over: start the next packet of the init job.
                  pkt_in  = pkt_ff + 2'd1;
                  byte_in = '0;
                  bit_in  = '0;
                  tx_in   = gpm_pkg::pkt_byte(pkt_ff + 2'd1, '0);
                  rx_in   = '0;
                  high_in = 1'b0;
                  gap_in  = 1'b0;
               end else if (!high_ff) begin
                  // Rising clock edge: sample the data line.
                  high_in = 1'b1;
                  rx_in   = rx_sampled;
                  if (bit_ff == 3'd7) begin
                     rx_valid    = 1'b1;
                     rx_byte     = rx_sampled;
                     rx_index    = byte_ff;
                     packet_last = (byte_next_cnt >= pkt_len);
                  end
               end else if (bit_ff != 3'd7) begin
                  // Falling clock edge inside a byte: next bit.
                  bit_in  = bit_ff + 3'd1;
                  high_in = 1'b0;
               end else if (byte_next_cnt < pkt_len) begin
                  // Falling clock edge after a byte: load the next byte.
                  byte_in = byte_next;
                  tx_in   = gpm_pkg::pkt_byte(pkt_ff, byte_next);
                  rx_in   = '0;
                  bit_in  = '0;
                  high_in = 1'b0;
               end else begin
                  // End of packet: finish the job or insert a gap.
                  high_in = 1'b1;
                  if (mode_ff == gpm_pkg::MODE_POLL || pkt_ff == gpm_pkg::PKT_EXIT) begin
                     mode_in = gpm_pkg::MODE_IDLE;
                     done    = 1'b1;
                  end else begin
                     gap_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            // Idle: a start action launches a job with its first packet.
            if (action == gpm_pkg::ACT_POLL || action == gpm_pkg::ACT_INIT) begin
               mode_in = (action == gpm_pkg::ACT_POLL) ? gpm_pkg::MODE_POLL
                                                       : gpm_pkg::MODE_INIT;
               pkt_in  = gpm_pkg::PKT_POLL;
               byte_in = '0;
               bit_in  = '0;
               tx_in   = gpm_pkg::pkt_byte(gpm_pkg::PKT_POLL, '0);
               rx_in   = '0;
               high_in = 1'b0;
               gap_in  = 1'b0;
               tick_in = gpm_pkg::HALF_W'(1);
            end else begin
               mode_in = gpm_pkg::MODE_IDLE;
            end
         end
      endcase
   end

   // Pin levels after this tick.
   assign busy_next = (mode_in != gpm_pkg::MODE_IDLE);
   assign in_pkt    = busy_next && !gap_in;

   always_comb begin
      result.clock_pin     = in_pkt ? high_in : 1'b1;
      result.command_pin   = in_pkt ? tx_in[bit_in] : 1'b1;
      result.attention_pin = !in_pkt;
      result.rx_valid      = rx_valid;
      result.rx_byte       = rx_byte;
      result.rx_index      = rx_index;
      result.packet_last   = packet_last;
      result.sequence_done = done;
      result.busy_res      = busy_next;
   end

   // Half-period register.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= gpm_pkg::HALF_PERIOD_RESET;
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   // State update on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= gpm_pkg::MODE_IDLE;
         pkt_ff  <= '0;
         byte_ff <= '0;
         bit_ff  <= '0;
         high_ff <= 1'b1;
         gap_ff  <= 1'b0;
         tick_ff <= '0;
         tx_ff   <= '0;
         rx_ff   <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         pkt_ff  <= pkt_in;
         byte_ff <= byte_in;
         bit_ff  <= bit_in;
         high_ff <= high_in;
         gap_ff  <= gap_in;
         tick_ff <= tick_in;
         tx_ff   <= tx_in;
         rx_ff   <= rx_in;
      end
   end

   // A byte is completed only on the rising clock edge.
   assert property (@(posedge clock) disable iff (reset)
      result.rx_valid |-> result.clock_pin)
      else $error("byte completed while clock low");

   // The job ends with the block no longer busy.
   assert property (@(posedge clock) disable iff (reset)
      result.sequence_done |-> !result.busy_res)
      else $error("sequence done while still busy");

   // Gaps occur only between packets of an init job.
   assert property (@(posedge clock) disable iff (reset)
      gap_ff |-> (mode_ff == gpm_pkg::MODE_INIT && high_ff))
      else $error("gap outside an init job");

   // The byte position stays inside the current packet.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff != gpm_pkg::MODE_IDLE) |-> ({1'b0, byte_ff} < pkt_len))
      else $error("byte position beyond packet end");

endmodule

// ===== src/gpm_rsp_reg.sv =====
// Response register: holds one response until the receiver takes it.
// Depends on gpm_pkg for the result type.
module gpm_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  gpm_pkg::result_type  result_in,
   output logic                 load_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gpm_pkg::result_type  result_out
);

   logic                 valid_ff;
   gpm_pkg::result_type  data_ff;

   // A new response may load when the register is empty or drains this cycle.
   assign load_ready = !valid_ff || rsp_ready;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ready) begin
         valid_ff <= load;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = data_ff;

endmodule

// ===== src/gamepad_serial_poll_master.sv =====
// Top level of the gamepad serial poll master; uses gpm_pkg, gpm_engine and gpm_rsp_reg.
// The response to a request is registered and is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the response register can load; the engine
// steps on each accepted request, and a new request loads while the held one drains.
// Reset is synchronous and active high: the job goes idle and lines read high.
module gamepad_serial_poll_master #(
   parameter int PollBytes = gpm_pkg::POLL_BYTES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic                               req_data_pin,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_clock_pin,
   output logic                               rsp_command_pin,
   output logic                               rsp_attention_pin,
   output logic                               rsp_rx_valid,
   output logic [gpm_pkg::BYTE_W-1:0]         rsp_rx_byte,
   output logic [gpm_pkg::INDEX_W-1:0]        rsp_rx_index,
   output logic                               rsp_packet_last,
   output logic                               rsp_sequence_done,
   output logic                               rsp_busy_res,
   input  logic                               csr_wr_en,
   input  logic [gpm_pkg::HALF_W-1:0]         csr_wr_data
);

   logic                 step;
   gpm_pkg::result_type  result_next;
   gpm_pkg::result_type  result_held;

   // A request is taken whenever the response register can load.
   assign step = req_valid && req_ready;

   gpm_engine #(
      .PollBytes (PollBytes)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .action      (req_action),
      .data_pin    (req_data_pin),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (result_next)
   );

   gpm_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result_in  (result_next),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .result_out (result_held)
   );

   // Response fields.
   assign rsp_clock_pin     = result_held.clock_pin;
   assign rsp_command_pin   = result_held.command_pin;
   assign rsp_attention_pin = result_held.attention_pin;
   assign rsp_rx_valid      = result_held.rx_valid;
   assign rsp_rx_byte       = result_held.rx_byte;
   assign rsp_rx_index      = result_held.rx_index;
   assign rsp_packet_last   = result_held.packet_last;
   assign rsp_sequence_done = result_held.sequence_done;
   assign rsp_busy_res      = result_held.busy_res;

endmodule

// ===== tb/sv/gamepad_serial_poll_master_tb.sv =====
// Testbench for the gamepad serial poll master: directed and random request streams
// checked against a cycle-level predictor of the pin levels and received bytes.
// Depends on gpm_pkg and the gamepad_serial_poll_master top level.
`timescale 1ns / 100ps

module gamepad_serial_poll_master_tb;

   // Action code three has no meaning of its own and behaves as a plain tick.
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam logic [gpm_pkg::HALF_W-1:0] HALF_MAX = 16'hFFFF;
   localparam logic [gpm_pkg::HALF_W-1:0] HALF_ZERO = 16'h0000;
   localparam int PHASE_ITEMS = 480;
   localparam int REWRITE_EVERY = 200;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_action;
   logic                         req_data_pin;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_clock_pin;
   logic                         rsp_command_pin;
   logic                         rsp_attention_pin;
   logic                         rsp_rx_valid;
   logic [gpm_pkg::BYTE_W-1:0]   rsp_rx_byte;
   logic [gpm_pkg::INDEX_W-1:0]  rsp_rx_index;
   logic                         rsp_packet_last;
   logic                         rsp_sequence_done;
   logic                         rsp_busy_res;
   logic                         csr_wr_en;
   logic [gpm_pkg::HALF_W-1:0]   csr_wr_data;

   // Idle rates in percent for each side, and a receiver hold-off counted in cycles.
   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_cycles;
   int mismatch_count;

   // Predicted line levels and received bytes, oldest first.
   gpm_pkg::result_type pending_pin_levels[$];

   // Predictor state.
   logic [gpm_pkg::HALF_W-1:0]  half_ticks;
   gpm_pkg::mode_type           job_mode;
   logic [1:0]                  pkt_num;
   logic [gpm_pkg::INDEX_W-1:0] byte_pos;
   logic [2:0]                  bit_pos;
   logic                        clk_high;
   logic                        in_gap;
   logic [gpm_pkg::HALF_W-1:0]  tick_cnt;
   logic [gpm_pkg::BYTE_W-1:0]  tx_bits;
   logic [gpm_pkg::BYTE_W-1:0]  rx_bits;

   gamepad_serial_poll_master dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_data_pin      (req_data_pin),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_clock_pin     (rsp_clock_pin),
      .rsp_command_pin   (rsp_command_pin),
      .rsp_attention_pin (rsp_attention_pin),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_rx_index      (rsp_rx_index),
      .rsp_packet_last   (rsp_packet_last),
      .rsp_sequence_done (rsp_sequence_done),
      .rsp_busy_res      (rsp_busy_res),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // Free-running clock with a 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Number of bytes in each packet of a job.
   function automatic int packet_length(input logic [1:0] pkt);
      case (pkt)
         gpm_pkg::PKT_POLL:  return gpm_pkg::POLL_BYTES;
         gpm_pkg::PKT_ENTER: return int'(gpm_pkg::ENTER_LEN);
         default:            return int'(gpm_pkg::CFG_LEN);
      endcase
   endfunction

   // Command byte sent at a given position of a packet.
   function automatic logic [gpm_pkg::BYTE_W-1:0] command_byte(input logic [1:0] pkt,
                                                              input int pos);
      logic [gpm_pkg::BYTE_W-1:0] cmd;
      cmd = gpm_pkg::BYTE_ZERO;
      if (pos == 0) begin
         cmd = gpm_pkg::BYTE_HEADER;
      end else if (pos == 1) begin
         case (pkt)
            gpm_pkg::PKT_POLL:  cmd = gpm_pkg::BYTE_POLL;
            gpm_pkg::PKT_LOCK:  cmd = gpm_pkg::BYTE_ANALOG;
            default:            cmd = gpm_pkg::BYTE_CONFIG;
         endcase
      end else if (pkt == gpm_pkg::PKT_ENTER || pkt == gpm_pkg::PKT_LOCK) begin
         if (pos == 3) cmd = gpm_pkg::BYTE_HEADER;
         else if (pos == 4 && pkt == gpm_pkg::PKT_LOCK) cmd = gpm_pkg::BYTE_LOCK;
      end else if (pkt == gpm_pkg::PKT_EXIT && pos >= 4 && pos <= 8) begin
         cmd = gpm_pkg::BYTE_PAD;
      end
      return cmd;
   endfunction

   // Predictor state after reset.
   task automatic reset_predictor();
      half_ticks = gpm_pkg::HALF_PERIOD_RESET;
      job_mode = gpm_pkg::MODE_IDLE;
      pkt_num = gpm_pkg::PKT_POLL;
      byte_pos = '0;
      bit_pos = '0;
      clk_high = 1'b1;
      in_gap = 1'b0;
      tick_cnt = '0;
      tx_bits = '0;
      rx_bits = '0;
   endtask

   // A packet starts with the clock low and the first command bit on the line.
   task automatic open_packet();
      byte_pos = '0;
      bit_pos = '0;
      tx_bits = command_byte(pkt_num, 0);
      rx_bits = '0;
      clk_high = 1'b0;
      in_gap = 1'b0;
      tick_cnt = 16'd1;
   endtask

   // True when the next tick that completes a half period ends the whole job.
   function automatic bit job_ends_next();
      int h;
      h = (half_ticks == HALF_ZERO) ? 1 : int'(half_ticks);
      return job_mode != gpm_pkg::MODE_IDLE && !in_gap && clk_high && bit_pos == 3'd7
         && int'(byte_pos) + 1 >= packet_length(pkt_num) && int'(tick_cnt) >= h
         && (job_mode == gpm_pkg::MODE_POLL || pkt_num == gpm_pkg::PKT_EXIT);
   endfunction

   // Advance the predictor by one accepted request and queue the line levels it yields.
   task automatic predict_pin_tick(input logic [1:0] act, input logic pin);
      gpm_pkg::result_type lvl;
      int h;
      bit busy;
      bit framing;
      lvl = '0;
      h = (half_ticks == HALF_ZERO) ? 1 : int'(half_ticks);
      if (job_mode == gpm_pkg::MODE_IDLE) begin
         if (act == gpm_pkg::ACT_POLL || act == gpm_pkg::ACT_INIT) begin
            job_mode = (act == gpm_pkg::ACT_POLL) ? gpm_pkg::MODE_POLL : gpm_pkg::MODE_INIT;
            pkt_num = gpm_pkg::PKT_POLL;
            open_packet();
         end
      end else if (int'(tick_cnt) < h) begin
         tick_cnt = tick_cnt + 16'd1;
      end else begin
         tick_cnt = 16'd1;
         if (in_gap) begin
            // The gap is over; the next packet of the init job begins.
            in_gap = 1'b0;
            pkt_num = pkt_num + 2'd1;
            open_packet();
         end else if (!clk_high) begin
            // Rising clock edge: sample the data line.
            clk_high = 1'b1;
            rx_bits = rx_bits | (gpm_pkg::BYTE_W'(pin) << bit_pos);
            if (bit_pos == 3'd7) begin
               lvl.rx_valid = 1'b1;
               lvl.rx_byte = rx_bits;
               lvl.rx_index = byte_pos;
               lvl.packet_last = int'(byte_pos) + 1 >= packet_length(pkt_num);
            end
         end else if (bit_pos != 3'd7) begin
            bit_pos = bit_pos + 3'd1;
            clk_high = 1'b0;
         end else if (int'(byte_pos) + 1 < packet_length(pkt_num)) begin
            byte_pos = byte_pos + 5'd1;
            tx_bits = command_byte(pkt_num, int'(byte_pos));
            rx_bits = '0;
            bit_pos = '0;
            clk_high = 1'b0;
         end else begin
            // End of packet: either the job is done or a gap precedes the next packet.
            clk_high = 1'b1;
            if (job_mode == gpm_pkg::MODE_POLL || pkt_num == gpm_pkg::PKT_EXIT) begin
               job_mode = gpm_pkg::MODE_IDLE;
               lvl.sequence_done = 1'b1;
            end else begin
               in_gap = 1'b1;
            end
         end
      end
      busy = (job_mode != gpm_pkg::MODE_IDLE);
      framing = busy && !in_gap;
      lvl.clock_pin = framing ? clk_high : 1'b1;
      lvl.command_pin = framing ? tx_bits[bit_pos] : 1'b1;
      lvl.attention_pin = !framing;
      lvl.busy_res = busy;
      pending_pin_levels.push_back(lvl);
   endtask

   // Print one line per mismatch and count every one.
   task automatic report_error(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // Offer one request, idling first at the sender's rate, and wait for its acceptance.
   task automatic send_request(input logic [1:0] act, input logic pin);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_pin <= pin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pin_tick(act, pin);
   endtask

   // Stop offering requests and wait until every predicted response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_pin_levels.size() != 0) @(posedge clock);
   endtask

   // Write the half period register while no request is in flight.
   task automatic set_half_period(input logic [gpm_pkg::HALF_W-1:0] value);
      drain_responses();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      half_ticks = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [gpm_pkg::HALF_W-1:0] pick_half_period();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 16'd1;
      if (r < 90) return 16'd2;
      return gpm_pkg::HALF_W'($urandom_range(3, 8));
   endfunction

   // Plain ticks and the spare code leave an idle block idle.
   task automatic test_idle_codes();
      send_request(gpm_pkg::ACT_TICK, 1'b0);
      send_request(gpm_pkg::ACT_TICK, 1'b1);
      send_request(ACT_SPARE, 1'b1);
      send_request(ACT_SPARE, 1'b0);
   endtask

   // Starting an init job at the reset half period; later starts are ignored.
   task automatic test_init_start();
      send_request(gpm_pkg::ACT_INIT, 1'b1);
      send_request(gpm_pkg::ACT_TICK, 1'b0);
      send_request(gpm_pkg::ACT_TICK, 1'b1);
      send_request(gpm_pkg::ACT_TICK, 1'b1);
      send_request(gpm_pkg::ACT_POLL, 1'b0);
      send_request(gpm_pkg::ACT_INIT, 1'b1);
      send_request(ACT_SPARE, 1'b1);
      send_request(gpm_pkg::ACT_TICK, 1'b0);
   endtask

   // Largest half period, then zero, which behaves as one tick, in the middle of a job.
   task automatic test_period_extremes();
      set_half_period(HALF_MAX);
      repeat (4) send_request(gpm_pkg::ACT_TICK, 1'($urandom_range(1)));
      set_half_period(HALF_ZERO);
      repeat (8) send_request(gpm_pkg::ACT_TICK, 1'($urandom_range(1)));
   endtask

   // Random jobs with random data, stray starts and spare codes mixed in.
   task automatic test_random_jobs(input int send_pct, input int recv_pct, input int count);
      logic [1:0] act;
      int r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % REWRITE_EVERY == 0) set_half_period(pick_half_period());
         r = $urandom_range(99);
         if (job_mode == gpm_pkg::MODE_IDLE) begin
            if (r < 40) act = gpm_pkg::ACT_INIT;
            else if (r < 70) act = gpm_pkg::ACT_POLL;
            else if (r < 85) act = ACT_SPARE;
            else act = gpm_pkg::ACT_TICK;
         end else if (job_ends_next() || in_gap) begin
            // A start on the finishing tick or during a gap must be ignored.
            act = (r < 25) ? gpm_pkg::ACT_POLL : (r < 50) ? gpm_pkg::ACT_INIT
                                                          : gpm_pkg::ACT_TICK;
         end else begin
            if (r < 2) act = gpm_pkg::ACT_POLL;
            else if (r < 4) act = gpm_pkg::ACT_INIT;
            else if (r < 7) act = ACT_SPARE;
            else act = gpm_pkg::ACT_TICK;
         end
         send_request(act, 1'($urandom_range(1)));
      end
   endtask

   // The receiver holds off for a long stretch so the block fills and stalls its input,
   // then the sender pauses until every response is back.
   task automatic test_response_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_half_period(16'd1);
      rsp_hold_cycles = 80;
      send_request(gpm_pkg::ACT_POLL, 1'b1);
      repeat (39) send_request(gpm_pkg::ACT_TICK, 1'($urandom_range(1)));
      drain_responses();
   endtask

   // Receiver: ready at random, or held off for a counted number of cycles.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each accepted response with the oldest prediction.
   initial begin
      gpm_pkg::result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_pin_levels.size() == 0) begin
               report_error("response arrived with no request outstanding");
            end else begin
               want = pending_pin_levels.pop_front();
               check_field("clock_pin", rsp_clock_pin, want.clock_pin);
               check_field("command_pin", rsp_command_pin, want.command_pin);
               check_field("attention_pin", rsp_attention_pin, want.attention_pin);
               check_field("rx_valid", rsp_rx_valid, want.rx_valid);
               check_field("rx_byte", rsp_rx_byte, want.rx_byte);
               check_field("rx_index", rsp_rx_index, want.rx_index);
               check_field("packet_last", rsp_packet_last, want.packet_last);
               check_field("sequence_done", rsp_sequence_done, want.sequence_done);
               check_field("busy_res", rsp_busy_res, want.busy_res);
            end
         end
      end
   end

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Main sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = gpm_pkg::ACT_TICK;
      req_data_pin = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 15;
      recv_idle_pct = 61;
      rsp_hold_cycles = 0;
      mismatch_count = 0;
      reset_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_codes();
      test_init_start();
      test_period_extremes();
      test_random_jobs(15, 61, PHASE_ITEMS);
      test_random_jobs(61, 15, PHASE_ITEMS);
      test_response_stall();
      test_random_jobs(0, 0, PHASE_ITEMS);

      drain_responses();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/gpm_pkg.sv
src/gpm_engine.sv
src/gpm_rsp_reg.sv
src/gamepad_serial_poll_master.sv
tb/sv/gamepad_serial_poll_master_tb.sv
